[design/fapp_pkg.sv]
`default_nettype none
package fapp_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned DivSteps = 24;
  localparam logic [31:0] CordicStart = 32'd652032874;
  localparam logic [23:0] YawK = 24'd10937044;
  localparam logic [15:0] MinSpeed = 16'd26;

  localparam logic [13:0] WheelBaseRst = 14'd2790;
  localparam logic [12:0] MaxPreviewRst = 13'd1000;
  localparam logic [15:0] PreviewDistRst = 16'd5000;

  typedef enum logic [1:0] {
    RegWheelBase = 2'd0,
    RegMaxPreview = 2'd1,
    RegPreviewDist = 2'd2,
    RegPreviewEn = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
    logic               flip;
  } cordic_vec_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    r = 32'd0;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
      21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[design/front_axle_pose_predictor.sv]
// Front axle pose predictor.
// Input beats enter on start and are accepted whenever busy is low;
// busy stays low outside reset, so one pose can enter every clock cycle.
// Each beat yields exactly one result beat on the output ports, marked by
// done for a single cycle. The receiver cannot stall; results leave in order.
// The pipeline is 24 + 2*CORDIC_STAGES + 7 registers deep. A 24-cell
// restoring divider chain forms the preview time, then one CORDIC cell chain
// turns the rear heading and a second turns the predicted yaw, with short
// multiply stages between them.
// Configuration beats on cfg_valid_i/cfg_ready_o write registers by index and
// are meant only while no pose is in flight. Reset clears the registers to
// their defaults and empties the pipeline; no result appears during reset.
`default_nettype none
module front_axle_pose_predictor
  import fapp_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_rear_i,
  input  logic signed [31:0] y_rear_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] speed_long_i,
  input  logic signed [15:0] speed_lat_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  output logic               done,
  output logic signed [31:0] x_front_o,
  output logic signed [31:0] y_front_o,
  output logic signed [15:0] heading_front_o,
  output logic signed [15:0] speed_long_front_o,
  output logic signed [15:0] speed_lat_front_o,
  output logic        [12:0] preview_time_ms_o
);

  localparam int unsigned Lat = DivSteps + 2*CORDIC_STAGES + 7;
  localparam logic [22:0] Recip125 = 23'd4294968;

  typedef struct packed {
    logic signed [31:0] xr;
    logic signed [31:0] yr;
    logic signed [15:0] hd;
    logic signed [15:0] sl;
    logic signed [15:0] st;
    logic signed [15:0] lat;
  } carry_t;

  logic [13:0] wb_q;
  logic [12:0] maxp_q;
  logic [15:0] pdist_q;
  logic        pen_q;

  assign busy        = ~rst_ni;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q    <= WheelBaseRst;
      maxp_q  <= MaxPreviewRst;
      pdist_q <= PreviewDistRst;
      pen_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegWheelBase:   wb_q    <= cfg_data_i[13:0];
        RegMaxPreview:  maxp_q  <= cfg_data_i[12:0];
        RegPreviewDist: pdist_q <= cfg_data_i;
        RegPreviewEn:   pen_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-2:0], start & ~busy};
  end
  assign done = vld_q[Lat-1];

  // Stage 0: operand prep, lateral product.
  carry_t c0_q;
  logic [15:0] den0_q;
  logic [23:0] num0_q;
  logic        pen0_q;
  logic signed [29:0] p0_q;
  logic [15:0] av;

  assign av = speed_long_i[15] ? 16'(-speed_long_i) : speed_long_i;

  always_ff @(posedge clk_i) begin
    c0_q   <= '{xr: x_rear_i, yr: y_rear_i, hd: heading_i, sl: speed_long_i,
                st: speed_lat_i, lat: turn_rate_i};
    den0_q <= (av < MinSpeed) ? MinSpeed : av;
    num0_q <= {pdist_q, 8'd0};
    pen0_q <= pen_q;
    p0_q   <= 30'(turn_rate_i) * 30'($signed({1'b0, wb_q}));
  end

  // Stage 1: lateral rounding. Dividing by 16000 is a shift by 7 followed by
  // an exact reciprocal multiply for 125.
  carry_t c1_q, c1_d;
  logic [29:0] pabs;
  logic [29:0] prnd;
  logic [45:0] qprod;
  logic [16:0] qv;
  logic signed [17:0] lsum;
  assign pabs  = p0_q[29] ? 30'(-p0_q) : 30'(p0_q);
  assign prnd  = pabs + 30'd8000;
  assign qprod = {23'd0, prnd[29:7]} * {23'd0, Recip125};
  assign qv    = qprod[45:29];
  assign lsum  = 18'(c0_q.st) + (p0_q[29] ? -$signed({1'b0, qv})
                                          : $signed({1'b0, qv}));

  always_comb begin
    c1_d     = c0_q;
    c1_d.lat = (lsum > 18'sd32767) ? 16'sh7FFF :
               (lsum < -18'sd32768) ? 16'sh8000 : lsum[15:0];
  end

  logic [15:0] den1_q;
  logic [23:0] num1_q;
  logic        pen1_q;
  always_ff @(posedge clk_i) begin
    c1_q   <= c1_d;
    den1_q <= den0_q;
    num1_q <= num0_q;
    pen1_q <= pen0_q;
  end

  // Divider chain plus delay for side data.
  logic [24:0] rem [DivSteps+1];
  logic [23:0] num [DivSteps+1];
  logic [15:0] den [DivSteps+1];
  logic [23:0] quo [DivSteps+1];
  carry_t cd [DivSteps+1];
  logic [DivSteps:0] pend;
  assign rem[0] = '0;
  assign num[0] = num1_q;
  assign den[0] = den1_q;
  assign quo[0] = '0;
  assign cd[0]  = c1_q;
  assign pend[0] = pen1_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    fapp_div_cell u_div (
      .clk_i(clk_i), .rem_i(rem[g]), .num_i(num[g]), .den_i(den[g]), .quo_i(quo[g]),
      .rem_o(rem[g+1]), .num_o(num[g+1]), .den_o(den[g+1]), .quo_o(quo[g+1])
    );
    always_ff @(posedge clk_i) begin
      cd[g+1]   <= cd[g];
      pend[g+1] <= pend[g];
    end
  end

  // Stage T: tau clamp, yaw step product.
  carry_t ct_q;
  logic [12:0] tau_q;
  logic [12:0] tau_c;
  assign tau_c = !pend[DivSteps] ? 13'd0 :
                 (quo[DivSteps] > {11'd0, maxp_q}) ? maxp_q : quo[DivSteps][12:0];
  always_ff @(posedge clk_i) begin
    ct_q  <= cd[DivSteps];
    tau_q <= tau_c;
  end

  // Carry turn rate separately since lat slot now holds lateral output.
  logic signed [15:0] tr_d [DivSteps+2];
  assign tr_d[0] = c0_q.lat;
  for (genvar g = 0; g < DivSteps+1; g++) begin : g_tr
    always_ff @(posedge clk_i) tr_d[g+1] <= tr_d[g];
  end

  logic signed [29:0] trtau_q;
  carry_t cy_q;
  logic [12:0] tau_y_q;
  always_ff @(posedge clk_i) begin
    trtau_q <= 30'(tr_d[DivSteps+1]) * 30'($signed({1'b0, tau_c}));
  end

  // Stage Y: yaw product and rounding.
  logic signed [55:0] yprod;
  logic [31:0] yaw_q;
  logic [31:0] hd32_q;
  assign yprod = 56'(trtau_q) * 56'($signed({1'b0, YawK}));
  always_ff @(posedge clk_i) begin
    cy_q    <= ct_q;
    tau_y_q <= tau_q;
    yaw_q   <= {ct_q.hd, 16'd0} + 32'(((yprod + 56'sd32768) >>> 16));
    hd32_q  <= {ct_q.hd, 16'd0};
  end

  // First CORDIC on rear heading, second on predicted yaw (started later).
  logic signed [31:0] c1, s1, c2, s2;
  fapp_cordic #(.CordicStages(CORDIC_STAGES)) u_cor_a (
    .clk_i(clk_i), .ang_i(hd32_q), .cos_o(c1), .sin_o(s1));

  carry_t ca [CORDIC_STAGES+1];
  logic [12:0] ta [CORDIC_STAGES+1];
  logic [31:0] ya [CORDIC_STAGES+1];
  assign ca[0] = cy_q;
  assign ta[0] = tau_y_q;
  assign ya[0] = yaw_q;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_da
    always_ff @(posedge clk_i) begin
      ca[g+1] <= ca[g];
      ta[g+1] <= ta[g];
      ya[g+1] <= ya[g];
    end
  end

  // Travel: velocity products, then tau product.
  logic signed [48:0] vx_q, vy_q;
  carry_t cv_q;
  logic [12:0] tv_q;
  logic [31:0] yv_q;
  always_ff @(posedge clk_i) begin
    vx_q <= 49'(ca[CORDIC_STAGES].sl) * 49'(c1) - 49'(ca[CORDIC_STAGES].st) * 49'(s1);
    vy_q <= 49'(ca[CORDIC_STAGES].sl) * 49'(s1) + 49'(ca[CORDIC_STAGES].st) * 49'(c1);
    cv_q <= ca[CORDIC_STAGES];
    tv_q <= ta[CORDIC_STAGES];
    yv_q <= ya[CORDIC_STAGES];
  end

  logic signed [63:0] dxp, dyp;
  logic signed [31:0] dx_q, dy_q;
  assign dxp = 64'(vx_q) * 64'($signed({1'b0, tv_q}));
  assign dyp = 64'(vy_q) * 64'($signed({1'b0, tv_q}));
  carry_t cw_q;
  logic [12:0] tw_q;
  logic [31:0] yw_q;
  always_ff @(posedge clk_i) begin
    dx_q <= 32'((dxp + (64'sd1 <<< 37)) >>> 38);
    dy_q <= 32'((dyp + (64'sd1 <<< 37)) >>> 38);
    cw_q <= cv_q;
    tw_q <= tv_q;
    yw_q <= yv_q;
  end

  fapp_cordic #(.CordicStages(CORDIC_STAGES)) u_cor_b (
    .clk_i(clk_i), .ang_i(yw_q), .cos_o(c2), .sin_o(s2));

  carry_t cb [CORDIC_STAGES+1];
  logic [12:0] tb [CORDIC_STAGES+1];
  logic [31:0] yb [CORDIC_STAGES+1];
  logic signed [31:0] dxb [CORDIC_STAGES+1];
  logic signed [31:0] dyb [CORDIC_STAGES+1];
  assign cb[0] = cw_q;
  assign tb[0] = tw_q;
  assign yb[0] = yw_q;
  assign dxb[0] = dx_q;
  assign dyb[0] = dy_q;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_db
    always_ff @(posedge clk_i) begin
      cb[g+1]  <= cb[g];
      tb[g+1]  <= tb[g];
      yb[g+1]  <= yb[g];
      dxb[g+1] <= dxb[g];
      dyb[g+1] <= dyb[g];
    end
  end

  logic signed [46:0] ox, oy;
  logic signed [34:0] sx, sy;
  assign ox = 47'($signed({1'b0, wb_q})) * 47'(c2);
  assign oy = 47'($signed({1'b0, wb_q})) * 47'(s2);
  assign sx = 35'(cb[CORDIC_STAGES].xr) + 35'(dxb[CORDIC_STAGES])
            + 35'((ox + (47'sd1 <<< 29)) >>> 30);
  assign sy = 35'(cb[CORDIC_STAGES].yr) + 35'(dyb[CORDIC_STAGES])
            + 35'((oy + (47'sd1 <<< 29)) >>> 30);

  always_ff @(posedge clk_i) begin
    x_front_o <= (sx > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                 (sx < -35'sh80000000) ? 32'sh80000000 : sx[31:0];
    y_front_o <= (sy > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                 (sy < -35'sh80000000) ? 32'sh80000000 : sy[31:0];
    heading_front_o    <= 16'((yb[CORDIC_STAGES] + 32'h8000) >> 16);
    speed_long_front_o <= cb[CORDIC_STAGES].sl;
    speed_lat_front_o  <= cb[CORDIC_STAGES].lat;
    preview_time_ms_o  <= tb[CORDIC_STAGES];
  end

endmodule
`default_nettype wire

[design/fapp_cordic_cell.sv]
`default_nettype none
module fapp_cordic_cell
  import fapp_pkg::*;
#(
  parameter int unsigned Shift = 0
) (
  input  logic        clk_i,
  input  cordic_vec_t vec_i,
  output cordic_vec_t vec_o
);

  cordic_vec_t vec_d, vec_q;
  logic [31:0] atan_c;

  assign atan_c = (Shift < AtanEntries) ? atan_turn(Shift) : 32'd0;

  always_comb begin
    vec_d = vec_i;
    if (!vec_i.z[32]) begin
      vec_d.x = vec_i.x - (vec_i.y >>> Shift);
      vec_d.y = vec_i.y + (vec_i.x >>> Shift);
      vec_d.z = vec_i.z - $signed({1'b0, atan_c});
    end else begin
      vec_d.x = vec_i.x + (vec_i.y >>> Shift);
      vec_d.y = vec_i.y - (vec_i.x >>> Shift);
      vec_d.z = vec_i.z + $signed({1'b0, atan_c});
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule
`default_nettype wire

[design/fapp_cordic.sv]
`default_nettype none
module fapp_cordic
  import fapp_pkg::*;
#(
  parameter int unsigned CordicStages = CordicStagesDef
) (
  input  logic               clk_i,
  input  logic        [31:0] ang_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  cordic_vec_t chain [CordicStages+1];
  logic [31:0] ang_f;
  logic        flip;

  always_comb begin
    ang_f = ang_i;
    flip  = 1'b0;
    if (ang_i[31] != ang_i[30]) begin
      ang_f = ang_i - 32'h80000000;
      flip  = 1'b1;
    end
  end

  assign chain[0] = '{x: $signed(CordicStart), y: 32'sd0,
                      z: $signed({ang_f[31], ang_f}), flip: flip};

  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    fapp_cordic_cell #(.Shift(g)) u_cell (
      .clk_i(clk_i), .vec_i(chain[g]), .vec_o(chain[g+1])
    );
  end

  assign cos_o = chain[CordicStages].flip ? -chain[CordicStages].x : chain[CordicStages].x;
  assign sin_o = chain[CordicStages].flip ? -chain[CordicStages].y : chain[CordicStages].y;

endmodule
`default_nettype wire

[design/fapp_div_cell.sv]
`default_nettype none
module fapp_div_cell (
  input  logic        clk_i,
  input  logic [24:0] rem_i,
  input  logic [23:0] num_i,
  input  logic [15:0] den_i,
  input  logic [23:0] quo_i,
  output logic [24:0] rem_o,
  output logic [23:0] num_o,
  output logic [15:0] den_o,
  output logic [23:0] quo_o
);

  logic [24:0] sh;
  logic [24:0] diff;

  assign sh   = {rem_i[23:0], num_i[23]};
  assign diff = sh - {9'd0, den_i};

  always_ff @(posedge clk_i) begin
    rem_o <= diff[24] ? sh : diff;
    quo_o <= {quo_i[22:0], ~diff[24]};
    num_o <= {num_i[22:0], 1'b0};
    den_o <= den_i;
  end

endmodule
`default_nettype wire

[design/fapp_checker.sv]
`default_nettype none
module fapp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        cfg_ready_o,
  input logic [12:0] preview_time_ms_o
);

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !done)
    else $error("result during reset");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy outside reset");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config not ready");
  a_tau: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> preview_time_ms_o <= 13'd8191)
    else $error("tau range");

endmodule

bind front_axle_pose_predictor fapp_checker u_fapp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done(done),
  .cfg_ready_o(cfg_ready_o), .preview_time_ms_o(preview_time_ms_o)
);
`default_nettype wire
